/* rtl/fvn_pkg.sv */
`timescale 1ns / 1ps

package fvn_pkg;

	localparam int POS_FRAC = 40;
	localparam int PX_W     = 57;
	localparam int SUM_W    = 52;
	localparam int TOT_W    = 21;
	localparam int AMP_W    = 17;
	localparam int QUOT_W   = 32;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_FREQUENCY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PERSISTENCE    = 2'd2;

	localparam logic [3:0]  OCT_RESET  = 4'd5;
	localparam logic [23:0] FREQ_RESET = 24'd301990;
	localparam logic [15:0] PERS_RESET = 16'd34079;

	localparam logic [31:0] HASH_X  = 32'd374761393;
	localparam logic [31:0] HASH_Z  = 32'd668265263;
	localparam logic [31:0] HASH_XZ = HASH_X + HASH_Z;
	localparam logic [31:0] HASH_M  = 32'd1274126177;

	localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
	localparam logic [AMP_W-1:0]   AMP_ONE = 17'h1_0000;

	typedef struct packed {
		logic signed [PX_W-1:0]  px;
		logic signed [PX_W-1:0]  pz;
		logic signed [SUM_W-1:0] sum;
		logic [TOT_W-1:0]        total;
		logic [AMP_W-1:0]        amp;
	} oct_item_t;

endpackage

/* rtl/fvn_octave_cell.sv */
`timescale 1ns / 1ps

module fvn_octave_cell import fvn_pkg::*; #(
	parameter int OCT       = 0,
	parameter int FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [3:0] oct_count,
	input  logic [15:0] persistence,
	input  logic       in_valid,
	input  oct_item_t  in_item,
	output logic       out_valid,
	output oct_item_t  out_item
);

	localparam int KI = POS_FRAC - OCT;
	localparam int KF = KI - FRAC_BITS;
	localparam int FW = FRAC_BITS;
	localparam int UW = FRAC_BITS + 1;
	localparam int PW = 33 + UW + 1;
	localparam logic [FW+1:0] THREE_S = (FW + 2)'(3) << FW;

	function automatic logic [31:0] mix(input logic [31:0] n);
		logic signed [31:0] t;
		t = $signed(n) >>> 13;
		return n ^ t;
	endfunction

	logic active;
	assign active = (OCT == 0) || (4'(OCT) < oct_count);

	logic [7:0] v_q;
	oct_item_t it_s1, it_s2, it_s3, it_s4, it_s5, it_s6, it_s7, it_s8;

	// s1: lattice index and fraction
	logic signed [PX_W-1:0] shx, shz;
	logic [31:0] ix, iz;
	logic [FW-1:0] fx, fz;
	assign shx = in_item.px >>> KI;
	assign shz = in_item.pz >>> KI;
	assign ix  = shx[31:0];
	assign iz  = shz[31:0];
	assign fx  = in_item.px[KI-1:KF];
	assign fz  = in_item.pz[KI-1:KF];

	logic [31:0] ax_s1, az_s1;
	logic [FW-1:0] fx_s1, fz_s1;
	logic [2*FW-1:0] fx2_s1, fz2_s1;

	// s2: corner mix, smoothstep
	logic [31:0] n0;
	logic [FW+1:0] wx, wz;
	logic [2*FW+1:0] px_c, pz_c;
	assign n0 = ax_s1 + az_s1;
	assign wx = THREE_S - {1'b0, fx_s1, 1'b0};
	assign wz = THREE_S - {1'b0, fz_s1, 1'b0};
	assign px_c = fx2_s1[2*FW-1:FW] * wx;
	assign pz_c = fz2_s1[2*FW-1:FW] * wz;

	logic [31:0] h_s2 [4];
	logic [UW-1:0] ux_s2, uz_s2;

	// s3: corner values
	logic [31:0] m_c [4];
	logic signed [31:0] cv_s3 [4];
	logic [UW-1:0] ux_s3, uz_s3;
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			m_c[k] = h_s2[k] * HASH_M;
		end
	end

	// s4: horizontal lerp products
	logic signed [32:0] dt, db;
	logic signed [PW-1:0] pt_c, pb_c;
	assign dt = $signed({cv_s3[1][31], cv_s3[1]}) - $signed({cv_s3[0][31], cv_s3[0]});
	assign db = $signed({cv_s3[3][31], cv_s3[3]}) - $signed({cv_s3[2][31], cv_s3[2]});
	assign pt_c = dt * $signed({1'b0, ux_s3});
	assign pb_c = db * $signed({1'b0, ux_s3});

	logic signed [PW-1:0] pt_s4, pb_s4;
	logic signed [31:0] a_s4, c_s4;
	logic [UW-1:0] uz_s4, uz_s5;

	// s5: rows
	logic signed [PW-1:0] pts, pbs;
	assign pts = pt_s4 >>> FW;
	assign pbs = pb_s4 >>> FW;
	logic signed [31:0] top_s5, bot_s5;

	// s6: vertical lerp product
	logic signed [32:0] dv;
	logic signed [PW-1:0] pv_c;
	assign dv = $signed({bot_s5[31], bot_s5}) - $signed({top_s5[31], top_s5});
	assign pv_c = dv * $signed({1'b0, uz_s5});
	logic signed [PW-1:0] pv_s6;
	logic signed [31:0] top_s6;

	// s7: sample
	logic signed [PW-1:0] pvs;
	assign pvs = pv_s6 >>> FW;
	logic signed [31:0] smp_s7;

	// s8: accumulate
	logic signed [49:0] wprod;
	logic signed [SUM_W-1:0] wext;
	logic [AMP_W+15:0] am;
	oct_item_t acc_c;
	assign wprod = smp_s7 * $signed({1'b0, it_s7.amp});
	assign wext  = SUM_W'(wprod);
	assign am    = it_s7.amp * persistence;

	always_comb begin
		acc_c = it_s7;
		if (active) begin
			acc_c.sum   = it_s7.sum + wext;
			acc_c.total = it_s7.total + TOT_W'(it_s7.amp);
			acc_c.amp   = am[AMP_W+15:16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1  <= in_item;
			ax_s1  <= ix * HASH_X;
			az_s1  <= iz * HASH_Z;
			fx_s1  <= fx;
			fz_s1  <= fz;
			fx2_s1 <= fx * fx;
			fz2_s1 <= fz * fz;

			it_s2   <= it_s1;
			h_s2[0] <= mix(n0);
			h_s2[1] <= mix(n0 + HASH_X);
			h_s2[2] <= mix(n0 + HASH_Z);
			h_s2[3] <= mix(n0 + HASH_XZ);
			ux_s2   <= px_c[2*FW:FW];
			uz_s2   <= pz_c[2*FW:FW];

			it_s3 <= it_s2;
			for (int k = 0; k < 4; k++) begin
				cv_s3[k] <= ONE_Q30 - $signed({1'b0, m_c[k][30:0]});
			end
			ux_s3 <= ux_s2;
			uz_s3 <= uz_s2;

			it_s4 <= it_s3;
			pt_s4 <= pt_c;
			pb_s4 <= pb_c;
			a_s4  <= cv_s3[0];
			c_s4  <= cv_s3[2];
			uz_s4 <= uz_s3;

			it_s5  <= it_s4;
			top_s5 <= a_s4 + pts[31:0];
			bot_s5 <= c_s4 + pbs[31:0];
			uz_s5  <= uz_s4;

			it_s6  <= it_s5;
			pv_s6  <= pv_c;
			top_s6 <= top_s5;

			it_s7  <= it_s6;
			smp_s7 <= top_s6 + pvs[31:0];

			it_s8 <= acc_c;
		end
	end

	assign out_valid = v_q[7];
	assign out_item  = it_s8;

endmodule

/* rtl/fvn_divider.sv */
`timescale 1ns / 1ps

module fvn_divider import fvn_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [SUM_W-1:0] sum,
	input  logic [TOT_W-1:0]        total,
	output logic                    out_valid,
	output logic [QUOT_W-1:0]       quot,
	output logic                    neg
);

	localparam int SPS = 4;
	localparam int NST = QUOT_W / SPS;

	logic [SUM_W-1:0] mag;
	assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

	logic              v_s   [NST+1];
	logic              neg_s [NST+1];
	logic [TOT_W-1:0]  tot_s [NST+1];
	logic [TOT_W-1:0]  rem_s [NST+1];
	logic [QUOT_W-1:0] lo_s  [NST+1];
	logic [QUOT_W-1:0] q_s   [NST+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s[0] <= sum[SUM_W-1];
			tot_s[0] <= total;
			rem_s[0] <= TOT_W'(mag[SUM_W-1:QUOT_W]);
			lo_s[0]  <= mag[QUOT_W-1:0];
			q_s[0]   <= '0;
		end
	end

	for (genvar k = 0; k < NST; k++) begin : g_st
		logic [TOT_W-1:0]  r_c;
		logic [QUOT_W-1:0] l_c, q_c;

		always_comb begin
			logic [TOT_W:0] t;
			r_c = rem_s[k];
			l_c = lo_s[k];
			q_c = q_s[k];
			for (int j = 0; j < SPS; j++) begin
				t   = {r_c, l_c[QUOT_W-1]};
				l_c = l_c << 1;
				if (t >= {1'b0, tot_s[k]}) begin
					t   = t - {1'b0, tot_s[k]};
					q_c = {q_c[QUOT_W-2:0], 1'b1};
				end else begin
					q_c = {q_c[QUOT_W-2:0], 1'b0};
				end
				r_c = t[TOT_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[k+1] <= neg_s[k];
				tot_s[k+1] <= tot_s[k];
				rem_s[k+1] <= r_c;
				lo_s[k+1]  <= l_c;
				q_s[k+1]   <= q_c;
			end
		end
	end

	assign out_valid = v_s[NST];
	assign quot      = q_s[NST];
	assign neg       = neg_s[NST];

endmodule

/* rtl/fractal_value_noise_core.sv */
`timescale 1ns / 1ps

// Fractal value noise, one sample per item.
// Input channel: in_valid/in_ready with coord_x, coord_z (signed Q16.16).
// Output channel: out_valid/out_ready with noise_value (signed Q2.30).
// Config channel: cfg_valid/cfg_ready (always ready), cfg_index, cfg_data;
// index 0 octave_count, 1 base_frequency, 2 persistence. Write only when idle.
// Throughput: one item per cycle unless stalled. Each octave is a cell of 8 stages;
// an item passes the input register, the cells, the 9-stage radix-16 divider and
// the output register, in that order.
// Unused octaves pass the sum through, so latency does not depend on octave_count.
// Reset clears all valid bits and loads the register reset values.
// When out_valid is high and out_ready low, the whole pipeline holds and
// in_ready drops; a held item moves on the cycle out_ready returns.

module fractal_value_noise_core import fvn_pkg::*; #(
	parameter int MAX_OCTAVES = 8,
	parameter int FRAC_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [31:0]    coord_x,
	input  logic signed [31:0]    coord_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    noise_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [3:0]  octave_count_q;
	logic [23:0] base_frequency_q;
	logic [15:0] persistence_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q   <= OCT_RESET;
			base_frequency_q <= FREQ_RESET;
			persistence_q    <= PERS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OCTAVE_COUNT:   octave_count_q   <= cfg_data[3:0];
				CFG_BASE_FREQUENCY: base_frequency_q <= cfg_data;
				CFG_PERSISTENCE:    persistence_q    <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic adv;
	logic out_valid_q;
	logic signed [31:0] noise_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	logic      v_s0;
	oct_item_t it_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (adv) begin
			v_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_s0.px    <= coord_x * $signed({1'b0, base_frequency_q});
			it_s0.pz    <= coord_z * $signed({1'b0, base_frequency_q});
			it_s0.sum   <= '0;
			it_s0.total <= '0;
			it_s0.amp   <= AMP_ONE;
		end
	end

	logic      chain_v  [MAX_OCTAVES+1];
	oct_item_t chain_it [MAX_OCTAVES+1];

	assign chain_v[0]  = v_s0;
	assign chain_it[0] = it_s0;

	for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
		fvn_octave_cell #(
			.OCT       (i),
			.FRAC_BITS (FRAC_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (adv),
			.oct_count   (octave_count_q),
			.persistence (persistence_q),
			.in_valid    (chain_v[i]),
			.in_item     (chain_it[i]),
			.out_valid   (chain_v[i+1]),
			.out_item    (chain_it[i+1])
		);
	end

	logic              div_valid;
	logic [QUOT_W-1:0] div_quot;
	logic              div_neg;

	fvn_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (chain_v[MAX_OCTAVES]),
		.sum       (chain_it[MAX_OCTAVES].sum),
		.total     (chain_it[MAX_OCTAVES].total),
		.out_valid (div_valid),
		.quot      (div_quot),
		.neg       (div_neg)
	);

	logic [QUOT_W-1:0] qs;
	assign qs = (div_quot > QUOT_W'(ONE_Q30)) ? QUOT_W'(ONE_Q30) : div_quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			noise_q <= div_neg ? $signed(-qs) : $signed(qs);
		end
	end

	assign out_valid   = out_valid_q;
	assign noise_value = noise_q;

`ifndef NO_ASSERTIONS
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (noise_value <= ONE_Q30 && noise_value >= -ONE_Q30))
		else $error("noise_value out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> ($stable(v_s0) && $stable(div_valid)))
		else $error("pipeline moved during stall");

	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		chain_v[MAX_OCTAVES] |-> (chain_it[MAX_OCTAVES].total != '0))
		else $error("zero amplitude total at divider");
`endif

endmodule
